/* hdl/cbrt_pkg.sv */
`timescale 1ns / 1ps
package cbrt_pkg;
	localparam int LimbW   = 64;
	localparam int RadW    = 6 * LimbW;
	localparam int RootW   = 2 * LimbW;
	localparam int SqW     = 2 * RootW;
	localparam int RemW    = SqW + 6;
	localparam int StepW   = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_TRIAL,
		ST_DONE
	} cbrt_state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic trial;
	} cbrt_ctl_t;
endpackage

/* hdl/cube_root_384_bit_core.sv */
`timescale 1ns / 1ps
// channel | ports                                   | handshake
// input   | limb_zero..limb_five, limb_count        | start high while busy low
// result  | root_low, root_high                     | done strobe, one cycle
//
// One root runs from the accepting edge through 128 root bits, each a calc
// state (build trial term) and then a trial state (compare and subtract on
// the 262-bit adder path), and then the done state. Busy stays high through
// the done cycle, so a new beat is accepted only back in idle. Reset leaves
// the block idle. The receiver cannot stall: the result stays on the ports
// from the done cycle until the next beat is accepted.
module cube_root_384_bit_core import cbrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	input  logic [LimbW-1:0] limb_zero,
	input  logic [LimbW-1:0] limb_one,
	input  logic [LimbW-1:0] limb_two,
	input  logic [LimbW-1:0] limb_three,
	input  logic [LimbW-1:0] limb_four,
	input  logic [LimbW-1:0] limb_five,
	input  logic [2:0]       limb_count,
	output logic [LimbW-1:0] root_low,
	output logic [LimbW-1:0] root_high
);
	cbrt_ctl_t        ctl;
	logic [RadW-1:0]  rad;
	logic [RootW-1:0] root;

	// drop limbs above the count
	always_comb begin
		rad = {limb_count > 3'd5 ? limb_five  : '0,
		       limb_count > 3'd4 ? limb_four  : '0,
		       limb_count > 3'd3 ? limb_three : '0,
		       limb_count > 3'd2 ? limb_two   : '0,
		       limb_count > 3'd1 ? limb_one   : '0,
		       limb_count > 3'd0 ? limb_zero  : '0};
	end

	cbrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.busy(busy), .done(done), .ctl(ctl)
	);

	cbrt_unit u_unit (
		.clk(clk), .ctl(ctl), .rad_in(rad), .root(root)
	);

	assign root_low  = root[LimbW-1:0];
	assign root_high = root[RootW-1:LimbW];
endmodule

/* hdl/cbrt_ctrl.sv */
`timescale 1ns / 1ps
module cbrt_ctrl import cbrt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output cbrt_ctl_t ctl
);
	cbrt_state_t state_q, state_d;
	logic [StepW-1:0] cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_CALC;
			ST_CALC:  state_d = ST_TRIAL;
			ST_TRIAL: state_d = (cnt_q == '1) ? ST_DONE : ST_CALC;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		ctl.load  = (state_q == ST_IDLE) && start;
		ctl.calc  = (state_q == ST_CALC);
		ctl.trial = (state_q == ST_TRIAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load)
				cnt_q <= '0;
			else if (ctl.trial)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// a result beat only follows the last trial
	a_done_after_trial: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_TRIAL) && $past(cnt_q == '1))
		else $error("done without final trial");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && cnt_q == '0)
		else $error("accepted beat did not start a root");
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done held for more than one cycle");
endmodule

/* hdl/cbrt_unit.sv */
`timescale 1ns / 1ps
module cbrt_unit import cbrt_pkg::*; (
	input  logic             clk,
	input  cbrt_ctl_t        ctl,
	input  logic [RadW-1:0]  rad_in,
	output logic [RootW-1:0] root
);
	logic [RadW-1:0]  rad_q;
	logic [RootW-1:0] y_q;
	logic [SqW-1:0]   sq_q;
	logic [RemW-1:0]  rem_q, remsh_q, b_q;
	logic [RemW-1:0]  t, b_d;
	logic             fits;

	// 3*(y'^2 + y') + 1 with y' = 2y, y'^2 = 4*sq
	always_comb begin
		t    = {4'b0, sq_q, 2'b0} + {{(RemW-RootW-1){1'b0}}, y_q, 1'b0};
		b_d  = t + {t[RemW-2:0], 1'b0} + {{(RemW-1){1'b0}}, 1'b1};
		fits = (remsh_q >= b_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rad_q <= rad_in;
			y_q   <= '0;
			sq_q  <= '0;
			rem_q <= '0;
		end else if (ctl.calc) begin
			remsh_q <= {rem_q[RemW-4:0], rad_q[RadW-1 -: 3]};
			rad_q   <= {rad_q[RadW-4:0], 3'b0};
			b_q     <= b_d;
		end else if (ctl.trial) begin
			if (fits) begin
				rem_q <= remsh_q - b_q;
				y_q   <= {y_q[RootW-2:0], 1'b1};
				sq_q  <= {sq_q[SqW-3:0], 2'b0} + {{(SqW-RootW-2){1'b0}}, y_q, 2'b0}
					+ {{(SqW-1){1'b0}}, 1'b1};
			end else begin
				rem_q <= remsh_q;
				y_q   <= {y_q[RootW-2:0], 1'b0};
				sq_q  <= {sq_q[SqW-3:0], 2'b0};
			end
		end
	end

	assign root = y_q;
endmodule
